// ===== rtl/core/qrs_pkg.sv =====
// Package for the quadratic root solver: word types, root kinds, widths
// of the square root and divider chains, and the Q16.16 clip function.
// No dependencies.
package qrs_pkg;

  localparam int COEF_WIDTH = 16;            // signed Q8.8 coefficient
  localparam int FRAC       = 16;            // fraction bits of the roots
  localparam int OUT_WIDTH  = 32;            // signed Q16.16 root field

  // Discriminant D = B*B - 4*A*C and its magnitude
  localparam int PROD_WIDTH = 2 * COEF_WIDTH;
  localparam int DISC_WIDTH = 2 * COEF_WIDTH + 2;
  localparam int MAG_WIDTH  = 2 * COEF_WIDTH + 1;

  // floor(sqrt(|D| * 2^32)): one cell per root bit, two radicand bits per cell
  localparam int ROOT_WIDTH = (MAG_WIDTH + 2 * FRAC + 1) / 2;
  localparam int RAD_WIDTH  = 2 * ROOT_WIDTH;
  localparam int REM_WIDTH  = ROOT_WIDTH + 2;
  localparam int RAD_PAD    = RAD_WIDTH - MAG_WIDTH - 2 * FRAC;

  // -B*2^16 (or -C*2^16) and the divisor 2A (or B)
  localparam int NB_WIDTH   = COEF_WIDTH + FRAC + 1;
  localparam int DEN_WIDTH  = COEF_WIDTH + 2;

  // Divider: one cell per quotient bit
  localparam int NUM_WIDTH  = 2 * COEF_WIDTH + 2;   // numerator magnitude
  localparam int NUMS_WIDTH = NUM_WIDTH + 1;        // signed numerator
  localparam int DVS_WIDTH  = COEF_WIDTH + 1;       // divisor magnitude
  localparam int DREM_WIDTH = DVS_WIDTH + 1;

  localparam logic signed [NUMS_WIDTH-1:0] Q_MAX =
    {{(NUMS_WIDTH-OUT_WIDTH){1'b0}}, 1'b0, {(OUT_WIDTH-1){1'b1}}};
  localparam logic signed [NUMS_WIDTH-1:0] Q_MIN =
    {{(NUMS_WIDTH-OUT_WIDTH){1'b1}}, 1'b1, {(OUT_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_LINEAR   = 3'd1,
    KIND_DOUBLE   = 3'd2,
    KIND_TWO_REAL = 3'd3,
    KIND_COMPLEX  = 3'd4
  } root_kind_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;
  } coef_t;

  typedef struct packed {
    root_kind_t                  root_kind;
    logic signed [OUT_WIDTH-1:0] first_real;
    logic signed [OUT_WIDTH-1:0] first_imag;
    logic signed [OUT_WIDTH-1:0] second_real;
    logic signed [OUT_WIDTH-1:0] second_imag;
    logic                        saturated;
  } root_t;

  typedef struct packed {
    logic [REM_WIDTH-1:0]  rem;
    logic [ROOT_WIDTH-1:0] root;
    logic [RAD_WIDTH-1:0]  rad;
  } sqrt_state_t;

  typedef struct packed {
    logic [DREM_WIDTH-1:0] rem;
    logic [NUM_WIDTH-1:0]  quo;
    logic [NUM_WIDTH-1:0]  num;
    logic [DVS_WIDTH-1:0]  dvs;
  } div_state_t;

  typedef struct packed {
    logic                        sat;
    logic signed [OUT_WIDTH-1:0] val;
  } clip_t;

  // Clip a signed quotient to the Q16.16 range and flag the clip.
  function automatic clip_t clip_q(input logic signed [NUMS_WIDTH-1:0] v);
    clip_t r;
    r.sat = 1'b0;
    r.val = v[OUT_WIDTH-1:0];
    if (v > Q_MAX) begin
      r.sat = 1'b1;
      r.val = Q_MAX[OUT_WIDTH-1:0];
    end else if (v < Q_MIN) begin
      r.sat = 1'b1;
      r.val = Q_MIN[OUT_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/qrs_sqrt_cell.sv =====
// One cell of the square root chain: settles one root bit from two
// radicand bits. Depends on qrs_pkg.
module qrs_sqrt_cell (
  input  logic                 clk,
  input  logic                 adv,
  input  qrs_pkg::sqrt_state_t din,
  output qrs_pkg::sqrt_state_t dout
);
  import qrs_pkg::*;

  logic [REM_WIDTH-1:0] rem2;
  logic [REM_WIDTH-1:0] trial;
  logic                 ge;
  sqrt_state_t          cell_next;

  always_comb begin
    rem2            = {din.rem[REM_WIDTH-3:0], din.rad[RAD_WIDTH-1 -: 2]};
    trial           = {din.root, 2'b01};
    ge              = (rem2 >= trial);
    cell_next.rem   = ge ? (rem2 - trial) : rem2;
    cell_next.root  = {din.root[ROOT_WIDTH-2:0], ge};
    cell_next.rad   = {din.rad[RAD_WIDTH-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (adv) dout <= cell_next;
  end

endmodule

// ===== rtl/core/qrs_div_cell.sv =====
// One cell of the divider chain: settles one quotient bit by restoring
// subtraction. Depends on qrs_pkg.
module qrs_div_cell (
  input  logic                clk,
  input  logic                adv,
  input  qrs_pkg::div_state_t din,
  output qrs_pkg::div_state_t dout
);
  import qrs_pkg::*;

  logic [DREM_WIDTH-1:0] rem2;
  logic [DREM_WIDTH-1:0] dvs_x;
  logic                  ge;
  div_state_t            cell_next;

  always_comb begin
    rem2          = {din.rem[DREM_WIDTH-2:0], din.num[NUM_WIDTH-1]};
    dvs_x         = {1'b0, din.dvs};
    ge            = (rem2 >= dvs_x);
    cell_next.rem = ge ? (rem2 - dvs_x) : rem2;
    cell_next.quo = {din.quo[NUM_WIDTH-2:0], ge};
    cell_next.num = {din.num[NUM_WIDTH-2:0], 1'b0};
    cell_next.dvs = din.dvs;
  end

  always_ff @(posedge clk) begin
    if (adv) dout <= cell_next;
  end

endmodule

// ===== rtl/core/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: discriminant stages, square root
// cell chain, two divider cell chains and the output register.
// Depends on qrs_pkg, qrs_sqrt_cell and qrs_div_cell.
//
//  channel | valid      | stall      | word
//  --------+------------+------------+-------------------------------
//  coef    | coef_valid | coef_stall | coef (a, b, c in Q8.8)
//  root    | root_valid | root_stall | root (kind, two roots, Q16.16)
//
// One coefficient word enters per cycle while root is not stalled; each word
// passes 3 front stages, 33 square root cells, 1 numerator stage, 34 divider
// cells and 1 output register. The cell chains set the latency.
// Reset clears only the valid bits of every stage.
// The whole pipeline advances whenever the output register is empty or is
// being taken; a stall on a valid root word holds every stage and raises coef_stall.
module quadratic_root_solver (
  input  logic           clk,
  input  logic           rst,
  input  logic           coef_valid,
  output logic           coef_stall,
  input  qrs_pkg::coef_t coef,
  output logic           root_valid,
  input  logic           root_stall,
  output qrs_pkg::root_t root
);
  import qrs_pkg::*;

  typedef struct packed {
    root_kind_t                   kind;
    logic signed [NB_WIDTH-1:0]   nb;    // -B*2^16, or -C*2^16 for linear
    logic signed [DEN_WIDTH-1:0]  den;   // 2A, or B for linear
  } sq_side_t;

  typedef struct packed {
    root_kind_t kind;
    logic       neg_x;
    logic       neg_y;
  } dv_side_t;

  logic adv;

  // Front stages
  logic                          v0, v1;
  logic signed [COEF_WIDTH-1:0]  a0, b0, c0, a1, b1;
  logic signed [PROD_WIDTH-1:0]  bb1, ac1;

  // c travels beside the products for the linear case.
  logic signed [COEF_WIDTH-1:0] c0_hold;

  // Square root chain
  sqrt_state_t         sq      [ROOT_WIDTH+1];
  sq_side_t            sq_side [ROOT_WIDTH+1];
  logic [ROOT_WIDTH:0] sq_vld;
  sqrt_state_t         sq_init;
  sq_side_t            side_init;
  logic signed [DISC_WIDTH-1:0] disc;

  // Divider chains
  div_state_t         dx      [NUM_WIDTH+1];
  div_state_t         dy      [NUM_WIDTH+1];
  dv_side_t           dv_side [NUM_WIDTH+1];
  logic [NUM_WIDTH:0] dv_vld;
  div_state_t         dx_init, dy_init;
  dv_side_t           dside_init;
  logic signed [NUMS_WIDTH-1:0] num_x, num_y, s_ext, nb_ext;
  logic [DVS_WIDTH-1:0]         dvs_mag;

  // Output
  logic signed [NUMS_WIDTH-1:0] qv_x, qv_y;
  clip_t                        cl_x, cl_y, cl_ny;
  root_t                        root_next;

  // Advance whenever the output register is free or being taken.
  assign adv        = !root_valid || !root_stall;
  assign coef_stall = !adv;

  // Discriminant, kind, and the -B*2^16 / 2A operands (-C*2^16 / B for linear).
  always_comb begin
    disc = DISC_WIDTH'(bb1) - (DISC_WIDTH'(ac1) <<< 2);
    if (a1 == '0) begin
      side_init.kind = (b1 != '0) ? KIND_LINEAR : KIND_NONE;
      side_init.nb   = -(NB_WIDTH'(c0_hold) <<< FRAC);
      side_init.den  = DEN_WIDTH'(b1);
    end else begin
      if (disc == '0)     side_init.kind = KIND_DOUBLE;
      else if (disc > 0)  side_init.kind = KIND_TWO_REAL;
      else                side_init.kind = KIND_COMPLEX;
      side_init.nb   = -(NB_WIDTH'(b1) <<< FRAC);
      side_init.den  = DEN_WIDTH'(a1) <<< 1;
    end
    sq_init.rem  = '0;
    sq_init.root = '0;
    sq_init.rad  = {{RAD_PAD{1'b0}},
                    MAG_WIDTH'((disc < 0) ? -disc : disc),
                    {(2 * FRAC){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0         <= 1'b0;
      v1         <= 1'b0;
      sq_vld     <= '0;
      dv_vld     <= '0;
      root_valid <= 1'b0;
    end else if (adv) begin
      v0         <= coef_valid;
      v1         <= v0;
      sq_vld     <= {sq_vld[ROOT_WIDTH-1:0], v1};
      dv_vld     <= {dv_vld[NUM_WIDTH-1:0], sq_vld[ROOT_WIDTH]};
      root_valid <= dv_vld[NUM_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0         <= coef.coef_a;
      b0         <= coef.coef_b;
      c0         <= coef.coef_c;
      bb1        <= b0 * b0;
      ac1        <= a0 * c0;
      a1         <= a0;
      b1         <= b0;
      c0_hold    <= c0;
      sq[0]      <= sq_init;
      sq_side[0] <= side_init;
      for (int k = 0; k < ROOT_WIDTH; k++) sq_side[k+1] <= sq_side[k];
      dx[0]      <= dx_init;
      dy[0]      <= dy_init;
      dv_side[0] <= dside_init;
      for (int k = 0; k < NUM_WIDTH; k++) dv_side[k+1] <= dv_side[k];
      root       <= root_next;
    end
  end

  genvar g;
  generate
    for (g = 0; g < ROOT_WIDTH; g++) begin : g_sqrt
      qrs_sqrt_cell u_cell (.clk(clk), .adv(adv), .din(sq[g]), .dout(sq[g+1]));
    end
    for (g = 0; g < NUM_WIDTH; g++) begin : g_div
      qrs_div_cell u_cell_x (.clk(clk), .adv(adv), .din(dx[g]), .dout(dx[g+1]));
      qrs_div_cell u_cell_y (.clk(clk), .adv(adv), .din(dy[g]), .dout(dy[g+1]));
    end
  endgenerate

  // Numerators: two real roots take nb + s and nb - s; a complex pair takes
  // nb for the real part and s for the imaginary part.
  always_comb begin
    nb_ext = NUMS_WIDTH'(sq_side[ROOT_WIDTH].nb);
    s_ext  = signed'(NUMS_WIDTH'(sq[ROOT_WIDTH].root));
    num_x  = nb_ext;
    num_y  = '0;
    case (sq_side[ROOT_WIDTH].kind)
      KIND_TWO_REAL: begin
        num_x = nb_ext + s_ext;
        num_y = nb_ext - s_ext;
      end
      KIND_COMPLEX: begin
        num_y = s_ext;
      end
      default: begin
        num_y = '0;
      end
    endcase
    dvs_mag = DVS_WIDTH'((sq_side[ROOT_WIDTH].den < 0) ? -sq_side[ROOT_WIDTH].den
                                                       : sq_side[ROOT_WIDTH].den);
    dx_init.rem = '0;
    dx_init.quo = '0;
    dx_init.num = NUM_WIDTH'((num_x < 0) ? -num_x : num_x);
    dx_init.dvs = dvs_mag;
    dy_init.rem = '0;
    dy_init.quo = '0;
    dy_init.num = NUM_WIDTH'((num_y < 0) ? -num_y : num_y);
    dy_init.dvs = dvs_mag;
    dside_init.kind  = sq_side[ROOT_WIDTH].kind;
    dside_init.neg_x = (num_x < 0) ^ (sq_side[ROOT_WIDTH].den < 0);
    dside_init.neg_y = (num_y < 0) ^ (sq_side[ROOT_WIDTH].den < 0);
  end

  // Apply signs, clip, and zero the fields a kind does not use.
  always_comb begin
    qv_x = signed'(NUMS_WIDTH'(dx[NUM_WIDTH].quo));
    qv_y = signed'(NUMS_WIDTH'(dy[NUM_WIDTH].quo));
    if (dv_side[NUM_WIDTH].neg_x) qv_x = -qv_x;
    if (dv_side[NUM_WIDTH].neg_y) qv_y = -qv_y;
    cl_x  = clip_q(qv_x);
    cl_y  = clip_q(qv_y);
    cl_ny = clip_q(-qv_y);
    root_next           = '0;
    root_next.root_kind = dv_side[NUM_WIDTH].kind;
    case (dv_side[NUM_WIDTH].kind)
      KIND_LINEAR, KIND_DOUBLE: begin
        root_next.first_real = cl_x.val;
        root_next.saturated  = cl_x.sat;
      end
      KIND_TWO_REAL: begin
        root_next.first_real  = cl_x.val;
        root_next.second_real = cl_y.val;
        root_next.saturated   = cl_x.sat | cl_y.sat;
      end
      KIND_COMPLEX: begin
        root_next.first_real  = cl_x.val;
        root_next.second_real = cl_x.val;
        root_next.first_imag  = cl_y.val;
        root_next.second_imag = cl_ny.val;
        root_next.saturated   = cl_x.sat | cl_y.sat | cl_ny.sat;
      end
      default: begin
        root_next.root_kind = KIND_NONE;
      end
    endcase
  end

  // A settled square root leaves a remainder of at most twice the root.
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    sq_vld[ROOT_WIDTH] |->
      (sq[ROOT_WIDTH].rem <= REM_WIDTH'({sq[ROOT_WIDTH].root, 1'b0})))
    else $error("square root remainder out of range");

  // A settled quotient leaves a remainder below a nonzero divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (dv_vld[NUM_WIDTH] && dx[NUM_WIDTH].dvs != '0) |->
      (dx[NUM_WIDTH].rem < DREM_WIDTH'(dx[NUM_WIDTH].dvs)))
    else $error("divider remainder not below divisor");

  // A complex pair shares its real part.
  a_conj: assert property (@(posedge clk) disable iff (rst)
    (root_valid && root.root_kind == KIND_COMPLEX) |->
      (root.first_real == root.second_real))
    else $error("complex pair real parts differ");

  // No solution carries only zero fields.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (root_valid && root.root_kind == KIND_NONE) |->
      (root.first_real == '0 && root.first_imag == '0 &&
       root.second_real == '0 && root.second_imag == '0 && !root.saturated))
    else $error("no-solution word carries root data");

endmodule
